// ===== hw/rtl/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int CAPACITY  = 256;
    localparam int KEY_WIDTH = 32;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // fixed field widths at the ports
    localparam int IN_KEY_W  = 32;
    localparam int TAG_W     = 9;
    localparam int TOTAL_W   = 9;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_POP    = 1'b1
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [IN_KEY_W-1:0] key;
        logic [TAG_W-1:0]    payload;
    } t_in_item;

    typedef struct packed {
        logic                pop_valid;
        logic [IN_KEY_W-1:0] popped_key;
        logic [TAG_W-1:0]    popped_payload;
        logic                now_empty;
        logic                insert_ok;
        logic [TOTAL_W-1:0]  entry_total;
    } t_out_item;

    typedef struct packed {
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_W-1:0]     payload;
    } t_entry;

    // broadcast to every cell
    typedef struct packed {
        logic                 ins;
        logic                 pop;
        logic [KEY_WIDTH-1:0] key;
        logic [TAG_W-1:0]     payload;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_ifs.sv =====
`default_nettype none

interface spq_in_if;
    logic              valid;
    logic              ready;
    spq_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface spq_out_if;
    logic               valid;
    logic               ready;
    spq_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/spq_cell.sv =====
`default_nettype none

// One slot of the sorted row. Shifts right on insert, left on pop.
module spq_cell (
    input  wire logic                i_clk,
    input  wire spq_pkg::t_cell_ctrl i_ctrl,
    input  wire spq_pkg::t_entry     i_left,
    input  wire logic                i_left_gt,
    input  wire spq_pkg::t_entry     i_right,
    input  wire logic                i_occ,
    input  wire logic                i_tail,
    output spq_pkg::t_entry          o_entry,
    output logic                     o_gt
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // stored key strictly above the incoming one
    assign o_gt    = i_occ && (r_entry.key > i_ctrl.key);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.ins) begin
            if (i_left_gt) begin
                n_entry = i_left;
            end else if (o_gt || i_tail) begin
                n_entry.key     = i_ctrl.key;
                n_entry.payload = i_ctrl.payload;
            end
        end else if (i_ctrl.pop) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/stable_sorted_priority_queue.sv =====
`default_nettype none

// Stable sorted min-priority queue built as a row of shift cells.
// Input channel i_in (valid/ready) carries one item: op selects insert
// or pop; key and payload give the entry on insert. Equal keys leave in
// arrival order. Output channel o_out carries exactly one result item per
// input item: popped entry and pop_valid, insert_ok, now_empty and the
// entry count after the item.
// The result is registered and shows in the cycle after the input item
// is accepted. Throughput: one item per cycle while o_out.ready is high;
// every cell compares its key against the incoming one in parallel and
// moves in one step.
// Stall: i_in.ready stays high while the result register is empty or is
// being drained this cycle; if the receiver holds o_out.ready low, the
// result waits and no new item is taken.
// Reset (i_rst_n low, synchronous): entry count cleared to zero and the
// result register emptied. Cell contents are not cleared; cells at or past
// the count are never read, so no clearing pass is needed.
module stable_sorted_priority_queue (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out
);

    localparam int CAP   = spq_pkg::CAPACITY;
    localparam int CNT_W = spq_pkg::CNT_W;

    // entry count and result register
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    spq_pkg::t_out_item r_out_data;
    spq_pkg::t_out_item n_out_data;

    logic accept;
    logic is_ins;
    logic full;
    logic empty;
    logic pop_hit;
    logic ins_hit;

    spq_pkg::t_cell_ctrl ctrl;
    spq_pkg::t_entry     w_entry [CAP];
    logic                w_gt    [CAP];

    // -------------------------------------------------------------------
    // Handshake: result register frees up when drained
    // -------------------------------------------------------------------
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign accept      = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    assign is_ins  = (i_in.data.op == spq_pkg::OP_INSERT);
    assign full    = (r_count == CNT_W'(CAP));
    assign empty   = (r_count == '0);
    assign ins_hit = is_ins && !full;
    assign pop_hit = !is_ins && !empty;

    // broadcast to the row; key truncated/extended to the stored width
    always_comb begin
        ctrl.ins     = accept && ins_hit;
        ctrl.pop     = accept && pop_hit;
        ctrl.key     = spq_pkg::KEY_WIDTH'(i_in.data.key);
        ctrl.payload = i_in.data.payload;
    end

    // -------------------------------------------------------------------
    // Count and result
    // -------------------------------------------------------------------
    always_comb begin
        n_count = r_count;
        if (ins_hit) begin
            n_count = r_count + CNT_W'(1);
        end else if (pop_hit) begin
            n_count = r_count - CNT_W'(1);
        end

        n_out_data.pop_valid      = pop_hit;
        n_out_data.popped_key     = pop_hit ? spq_pkg::IN_KEY_W'(w_entry[0].key) : '0;
        n_out_data.popped_payload = pop_hit ? w_entry[0].payload : '0;
        n_out_data.now_empty      = (n_count == '0);
        n_out_data.insert_ok      = ins_hit;
        n_out_data.entry_total    = spq_pkg::TOTAL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    // -------------------------------------------------------------------
    // Cell row: slot 0 holds the smallest key (the head)
    // -------------------------------------------------------------------
    for (genvar gi = 0; gi < CAP; gi++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(gi);

        spq_pkg::t_entry left_e;
        spq_pkg::t_entry right_e;
        logic            left_gt;

        if (gi == 0) begin : g_head
            assign left_e  = '0;
            assign left_gt = 1'b0;
        end else begin : g_mid
            assign left_e  = w_entry[gi-1];
            assign left_gt = w_gt[gi-1];
        end

        if (gi == CAP - 1) begin : g_last
            assign right_e = '0;
        end else begin : g_body
            assign right_e = w_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk     (i_clk),
            .i_ctrl    (ctrl),
            .i_left    (left_e),
            .i_left_gt (left_gt),
            .i_right   (right_e),
            .i_occ     (r_count > IDX),
            .i_tail    (r_count == IDX),
            .o_entry   (w_entry[gi]),
            .o_gt      (w_gt[gi])
        );
    end

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAP))
        else $error("entry count above capacity");

    a_ins_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ctrl.ins) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not grow the count");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && ctrl.pop) |=> (r_out_valid && r_out_data.pop_valid
                                  && r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop result or count wrong");

    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_entry[0].key <= w_entry[1].key))
        else $error("head of row out of order");

    a_reject_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_ins && full) |=> (!r_out_data.insert_ok
                                        && r_count == CNT_W'(CAP)))
        else $error("insert into full queue not rejected");

endmodule

`default_nettype wire
